FILE: hdl/assert_macros.svh
// Assertion macros shared by the generator RTL.
// No dependencies; each file that asserts includes this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on clk, off during rst.
`define PPG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk, off during rst.
`define PPG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/ppg_pkg.sv
// Shared types and constants of the polynomial phase pattern generator.
// No dependencies; used by every module of the block.
package ppg_pkg;

  localparam int COORD_BITS = 10;

  localparam logic [1:0] MODE_COEF  = 2'd0;
  localparam logic [1:0] MODE_TERM  = 2'd1;
  localparam logic [1:0] MODE_PIXEL = 2'd2;

  localparam logic [1:0] REG_X_DEGREE    = 2'd0;
  localparam logic [1:0] REG_Y_DEGREE    = 2'd1;
  localparam logic [1:0] REG_TERM_COUNT  = 2'd2;
  localparam logic [1:0] REG_PHASE_STEPS = 2'd3;

  // pi in unsigned Q4.60, split for the angle scaling
  localparam logic [63:0] Q_PI   = 64'h3243_F6A8_885A_308D;
  localparam logic [63:0] QPI_HI = Q_PI >> 15;
  localparam logic [63:0] QPI_LO = Q_PI & 64'h7FFF;
  localparam logic [63:0] Q_ONE  = 64'h1000_0000_0000_0000;

  typedef struct packed {
    logic [1:0]            mode;
    logic [5:0]            slot;
    logic signed [15:0]    coeff_value;
    logic signed [15:0]    term_scale;
    logic [15:0]           term_divisor;
    logic [COORD_BITS-1:0] x_coord;
    logic [COORD_BITS-1:0] y_coord;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        phase_index;
    logic signed [15:0] cos_value;
    logic signed [15:0] sin_value;
  } out_item_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quotient;
    logic [15:0] remainder;
  } div_rsp_t;

endpackage

FILE: hdl/polynomial_phase_pattern_generator_unit.sv
// Polynomial phase pattern generator. Coefficient and term write transactions
// (modes 0 and 1) are written when accepted. A pixel transaction (mode 2) returns
// one result; a term with a zero divisor is skipped. The processing time is set by
// the shared divider (24 of its divisions fall in the sin/cos series) and the
// 64x64 fixed-point product built from 32x32 partial products. One transaction is
// processed at a time; a finished result waits in the output register while the
// next transaction is taken. Coefficient memory entries read as zero until
// written; no clearing pass.
`include "assert_macros.svh"

module polynomial_phase_pattern_generator_unit
  import ppg_pkg::*;
#(
  parameter int MAX_TERMS  = 4,
  parameter int MAX_DEGREE = 3
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item,
  input  logic      cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int DS  = MAX_DEGREE + 1;
  localparam int CD  = MAX_TERMS * DS * DS;
  localparam int MD  = (CD < 64) ? CD : 64;
  localparam int DW  = (MAX_DEGREE > 0) ? $clog2(MAX_DEGREE + 1) : 1;
  localparam int TW  = $clog2(MAX_TERMS + 1);
  localparam int TAW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int RAW = (CD > 1) ? $clog2(CD) : 1;

  logic [1:0]  x_degree;
  logic [1:0]  y_degree;
  logic [2:0]  term_count;
  logic [15:0] phase_steps;

  logic [MAX_TERMS-1:0][15:0] scale_tab;
  logic [MAX_TERMS-1:0][15:0] div_tab;

  logic           accept;
  logic           core_idle;
  logic           res_hold;
  logic           res_ack;
  out_item_t      core_res;
  logic           rd_en;
  logic [RAW-1:0] rd_addr;
  logic [15:0]    rd_data;
  div_req_t       div_req;
  div_rsp_t       div_rsp;
  logic [DW-1:0]  dx;
  logic [DW-1:0]  dy;
  logic [TW-1:0]  nterms;

  assign in_ready = core_idle;
  assign accept   = in_valid && in_ready;

  // saturate the configuration to what the storage holds
  assign dx     = (32'(x_degree) > MAX_DEGREE) ? DW'(MAX_DEGREE) : DW'(x_degree);
  assign dy     = (32'(y_degree) > MAX_DEGREE) ? DW'(MAX_DEGREE) : DW'(y_degree);
  assign nterms = (32'(term_count) > MAX_TERMS) ? TW'(MAX_TERMS) : TW'(term_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      x_degree    <= 2'd0;
      y_degree    <= 2'd0;
      term_count  <= 3'd1;
      phase_steps <= 16'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_X_DEGREE:    x_degree    <= cfg_data[1:0];
        REG_Y_DEGREE:    y_degree    <= cfg_data[1:0];
        REG_TERM_COUNT:  term_count  <= cfg_data[2:0];
        REG_PHASE_STEPS: phase_steps <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t < MAX_TERMS; t++) begin
        scale_tab[t] <= 16'd0;
        div_tab[t]   <= 16'd1;
      end
    end else if (accept && (in_item.mode == MODE_TERM) &&
                 (32'(in_item.slot) < MAX_TERMS)) begin
      scale_tab[in_item.slot[TAW-1:0]] <= in_item.term_scale;
      div_tab[in_item.slot[TAW-1:0]]   <= in_item.term_divisor;
    end
  end

  ppg_coef_mem #(
    .DEPTH (MD),
    .RAW   (RAW)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept && (in_item.mode == MODE_COEF)),
    .wr_addr (in_item.slot),
    .wr_data (in_item.coeff_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ppg_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  ppg_core #(
    .MAX_TERMS  (MAX_TERMS),
    .MAX_DEGREE (MAX_DEGREE),
    .DW         (DW),
    .TW         (TW),
    .RAW        (RAW)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .start       (accept && (in_item.mode == MODE_PIXEL)),
    .x_in        (in_item.x_coord),
    .y_in        (in_item.y_coord),
    .dx          (dx),
    .dy          (dy),
    .nterms      (nterms),
    .phase_steps (phase_steps),
    .scale_tab   (scale_tab),
    .div_tab     (div_tab),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .div_req     (div_req),
    .div_rsp     (div_rsp),
    .idle        (core_idle),
    .res_hold    (res_hold),
    .res_ack     (res_ack),
    .result      (core_res)
  );

  // move the finished result into the output slot once it is free
  assign res_ack = res_hold && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ack) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ack) begin
      out_item <= core_res;
    end
  end

  `PPG_ASSERT_NEXT(a_pixel_blocks, accept && (in_item.mode == MODE_PIXEL), !in_ready, "pixel transaction did not occupy the sequencer")
  `PPG_ASSERT_IMP(a_index_range, out_valid, ((phase_steps == 16'd0) && (out_item.phase_index == 16'd0)) || (out_item.phase_index < phase_steps), "phase index out of range")
  `PPG_ASSERT_IMP(a_q15_range, out_valid, (out_item.cos_value != 16'sh8000) && (out_item.sin_value != 16'sh8000), "trig value outside Q1.15 range")

endmodule

FILE: hdl/ppg_coef_mem.sv
// Coefficient memory: one write port, one registered read port.
// Per-entry valid bits make unwritten entries read as zero. Uses ppg_pkg.
module ppg_coef_mem
  import ppg_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int RAW   = 6
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  logic [5:0]     wr_addr,
  input  logic [15:0]    wr_data,
  input  logic           rd_en,
  input  logic [RAW-1:0] rd_addr,
  output logic [15:0]    rd_data
);

  localparam int MAW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [15:0]      mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [15:0]      data_q;
  logic             ok_q;
  logic             wr_hit;
  logic             rd_hit;

  assign wr_hit = wr_en && (32'(wr_addr) < DEPTH);
  assign rd_hit = rd_en && (32'(rd_addr) < DEPTH);

  always_ff @(posedge clk) begin
    if (wr_hit) begin
      mem[wr_addr[MAW-1:0]] <= wr_data;
    end
    if (rd_en) begin
      data_q <= mem[rd_addr[MAW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      ok_q <= 1'b0;
    end else begin
      if (wr_hit) begin
        vld[wr_addr[MAW-1:0]] <= 1'b1;
      end
      if (rd_en) begin
        ok_q <= rd_hit ? vld[rd_addr[MAW-1:0]] : 1'b0;
      end
    end
  end

  assign rd_data = ok_q ? data_q : 16'd0;

endmodule

FILE: hdl/ppg_div.sv
// Shared unsigned divider, 64-bit dividend by 16-bit divisor, two bits a cycle.
// Uses the request and response structs of ppg_pkg.
module ppg_div
  import ppg_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic        busy;
  logic [4:0]  cnt;
  logic [63:0] dvd;
  logic [63:0] quo;
  logic [15:0] rem;
  logic [15:0] dsr;
  logic        done;

  logic [63:0] dvd_next;
  logic [63:0] quo_next;
  logic [15:0] rem_next;

  always_comb begin
    logic [16:0] t;
    dvd_next = dvd;
    quo_next = quo;
    rem_next = rem;
    for (int s = 0; s < 2; s++) begin
      t        = {rem_next, dvd_next[63]};
      dvd_next = {dvd_next[62:0], 1'b0};
      if (t >= {1'b0, dsr}) begin
        rem_next = 16'(t - {1'b0, dsr});
        quo_next = {quo_next[62:0], 1'b1};
      end else begin
        rem_next = t[15:0];
        quo_next = {quo_next[62:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        dvd  <= req.dividend;
        dsr  <= req.divisor;
        quo  <= '0;
        rem  <= '0;
      end else if (busy) begin
        dvd <= dvd_next;
        quo <= quo_next;
        rem <= rem_next;
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

FILE: hdl/ppg_core.sv
// Pixel sequencer: Horner evaluation over the coefficient memory, term
// division and scaling, modulo, turn fraction and sin/cos series. Uses ppg_pkg.
module ppg_core
  import ppg_pkg::*;
#(
  parameter int MAX_TERMS  = 4,
  parameter int MAX_DEGREE = 3,
  parameter int DW         = 2,
  parameter int TW         = 3,
  parameter int RAW        = 6
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [COORD_BITS-1:0]       x_in,
  input  logic [COORD_BITS-1:0]       y_in,
  input  logic [DW-1:0]               dx,
  input  logic [DW-1:0]               dy,
  input  logic [TW-1:0]               nterms,
  input  logic [15:0]                 phase_steps,
  input  logic [MAX_TERMS-1:0][15:0]  scale_tab,
  input  logic [MAX_TERMS-1:0][15:0]  div_tab,
  output logic                        rd_en,
  output logic [RAW-1:0]              rd_addr,
  input  logic [15:0]                 rd_data,
  output div_req_t                    div_req,
  input  div_rsp_t                    div_rsp,
  output logic                        idle,
  output logic                        res_hold,
  input  logic                        res_ack,
  output out_item_t                   result
);

  localparam int DS  = MAX_DEGREE + 1;
  localparam int TS  = DS * DS;
  localparam int TAW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

  typedef enum logic [4:0] {
    S_IDLE, S_TERM, S_ROW, S_RD, S_MAC, S_OUTER, S_DIVS, S_DIVW, S_ACC,
    S_MOD, S_MODW, S_FRACW, S_ANG1, S_ANG2, S_QMUL, S_QRET, S_SINIT,
    S_SDIVW, S_SEND, S_FIN, S_HOLD
  } state_t;

  state_t                state;
  logic [COORD_BITS-1:0] xr;
  logic [COORD_BITS-1:0] yr;
  logic [TW-1:0]         k;
  logic [DW-1:0]         i;
  logic [DW-1:0]         j;
  logic [63:0]           inner;
  logic [63:0]           poly;
  logic                  pneg;
  logic [63:0]           qv;
  logic [63:0]           sum;
  logic                  sneg;
  logic [15:0]           idx;
  logic [15:0]           tfrac;
  logic                  swap;
  logic [13:0]           rr;
  logic [63:0]           ang;
  logic [63:0]           a2;
  logic [63:0]           opa;
  logic [63:0]           opb;
  logic [127:0]          acc;
  logic [1:0]            qc;
  logic                  qm_a2;
  logic                  odd;
  logic [3:0]            n;
  logic [63:0]           ssum;
  logic [15:0]           sa;
  logic [15:0]           ca;
  logic [15:0]           cos_r;
  logic [15:0]           sin_r;

  logic [TAW-1:0]        kidx;
  logic [63:0]           coef;
  logic [63:0]           pp;
  logic [6:0]            shamt;
  logic [63:0]           qres;
  logic signed [80:0]    sprod;
  logic [15:0]           mval;
  logic [15:0]           idx_mod;
  logic [14:0]           rdiff;
  logic [28:0]           lo_part;
  logic [63:0]           ang_next;
  logic [63:0]           term_init;
  logic [15:0]           cq;
  logic [15:0]           sq;

  function automatic logic [15:0] series_div(input logic [3:0] nn, input logic is_odd);
    logic [4:0] m;
    logic [9:0] d;
    m = {nn, 1'b0};
    if (is_odd) begin
      d = 10'(m) * 10'(m + 5'd1);
    end else begin
      d = 10'(m - 5'd1) * 10'(m);
    end
    return 16'(d);
  endfunction

  // round(32767 * v) on a Q4.60 value
  function automatic logic [15:0] to_q15(input logic [63:0] v);
    logic [63:0] hi;
    logic [63:0] lo;
    hi = {30'd0, v[63:30]} * 64'd32767 + 64'd536870912;
    lo = {34'd0, v[29:0]} * 64'd32767;
    return 16'((hi + (lo >> 30)) >> 30);
  endfunction

  assign kidx    = k[TAW-1:0];
  assign rd_en   = (state == S_RD);
  assign rd_addr = RAW'(32'(k) * TS + 32'(i) * DS + 32'(j));
  assign coef    = {{48{rd_data[15]}}, rd_data};

  always_comb begin
    logic [63:0] ha;
    logic [63:0] hb;
    ha = qc[1] ? {32'd0, opa[63:32]} : {32'd0, opa[31:0]};
    hb = qc[0] ? {32'd0, opb[63:32]} : {32'd0, opb[31:0]};
    pp = ha * hb;
    unique case (qc)
      2'd0:    shamt = 7'd0;
      2'd3:    shamt = 7'd64;
      default: shamt = 7'd32;
    endcase
  end

  assign qres      = acc[123:60];
  assign sprod     = $signed(scale_tab[kidx]) * $signed({1'b0, qv});
  assign mval      = div_rsp.remainder;
  assign idx_mod   = (sneg && (mval != 16'd0)) ? (phase_steps - mval) : mval;
  assign rdiff     = 15'd16384 - {1'b0, tfrac[13:0]};
  assign lo_part   = {15'd0, rr} * {14'd0, QPI_LO[14:0]};
  assign ang_next  = ang + {49'd0, lo_part[28:15]};
  assign term_init = odd ? ang : Q_ONE;
  assign cq        = swap ? sa : ca;
  assign sq        = swap ? ca : sa;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      div_req.start <= 1'b0;
    end else begin
      div_req.start <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            xr    <= x_in;
            yr    <= y_in;
            k     <= '0;
            sum   <= '0;
            state <= S_TERM;
          end
        end
        S_TERM: begin
          if (k == nterms) begin
            state <= S_MOD;
          end else if (div_tab[kidx] == 16'd0) begin
            // zero divisor: term contributes nothing
            k <= k + 1'b1;
          end else begin
            i     <= dx;
            poly  <= '0;
            state <= S_ROW;
          end
        end
        S_ROW: begin
          inner <= '0;
          j     <= dy;
          state <= S_RD;
        end
        S_RD: begin
          state <= S_MAC;
        end
        S_MAC: begin
          inner <= inner * 64'(yr) + coef;
          if (j == '0) begin
            state <= S_OUTER;
          end else begin
            j     <= j - 1'b1;
            state <= S_RD;
          end
        end
        S_OUTER: begin
          poly <= poly * 64'(xr) + inner;
          if (i == '0) begin
            state <= S_DIVS;
          end else begin
            i     <= i - 1'b1;
            state <= S_ROW;
          end
        end
        S_DIVS: begin
          pneg             <= poly[63];
          div_req.start    <= 1'b1;
          div_req.dividend <= poly[63] ? (64'd0 - poly) : poly;
          div_req.divisor  <= div_tab[kidx];
          state            <= S_DIVW;
        end
        S_DIVW: begin
          if (div_rsp.done) begin
            qv    <= pneg ? (64'd0 - div_rsp.quotient) : div_rsp.quotient;
            state <= S_ACC;
          end
        end
        S_ACC: begin
          sum   <= sum + sprod[63:0];
          k     <= k + 1'b1;
          state <= S_TERM;
        end
        S_MOD: begin
          if (phase_steps == 16'd0) begin
            idx   <= '0;
            cos_r <= 16'd32767;
            sin_r <= '0;
            state <= S_HOLD;
          end else begin
            sneg             <= sum[63];
            div_req.start    <= 1'b1;
            div_req.dividend <= sum[63] ? (64'd0 - sum) : sum;
            div_req.divisor  <= phase_steps;
            state            <= S_MODW;
          end
        end
        S_MODW: begin
          if (div_rsp.done) begin
            idx              <= idx_mod;
            div_req.start    <= 1'b1;
            div_req.dividend <= {32'd0, idx_mod, 16'd0};
            div_req.divisor  <= phase_steps;
            state            <= S_FRACW;
          end
        end
        S_FRACW: begin
          if (div_rsp.done) begin
            tfrac <= div_rsp.quotient[15:0];
            state <= S_ANG1;
          end
        end
        S_ANG1: begin
          // fold the quadrant remainder into 0..pi/4
          swap  <= (tfrac[13:0] > 14'd8192);
          rr    <= (tfrac[13:0] > 14'd8192) ? rdiff[13:0] : tfrac[13:0];
          odd   <= 1'b1;
          state <= S_ANG2;
        end
        S_ANG2: begin
          ang   <= {50'd0, rr} * {15'd0, QPI_HI[48:0]};
          state <= S_QMUL;
          qm_a2 <= 1'b1;
          qc    <= '0;
          acc   <= '0;
          // operands are loaded on the first product cycle
          opa   <= '0;
          opb   <= '0;
        end
        S_QMUL: begin
          if (qm_a2 && (qc == 2'd0) && (opa == 64'd0) && (opb == 64'd0) &&
              (acc == 128'd0)) begin
            // finish the angle and square it
            ang <= ang_next;
            opa <= ang_next;
            opb <= ang_next;
            if (ang_next == 64'd0) begin
              state <= S_QRET;
            end
          end else begin
            acc <= acc + ({64'd0, pp} << shamt);
            qc  <= qc + 2'd1;
            if (qc == 2'd3) begin
              state <= S_QRET;
            end
          end
        end
        S_QRET: begin
          if (qm_a2) begin
            a2    <= qres;
            qm_a2 <= 1'b0;
            state <= S_SINIT;
          end else begin
            div_req.start    <= 1'b1;
            div_req.dividend <= qres;
            div_req.divisor  <= series_div(n, odd);
            state            <= S_SDIVW;
          end
        end
        S_SINIT: begin
          ssum  <= term_init;
          n     <= 4'd1;
          opa   <= term_init;
          opb   <= a2;
          acc   <= '0;
          qc    <= '0;
          state <= S_QMUL;
        end
        S_SDIVW: begin
          if (div_rsp.done) begin
            ssum <= n[0] ? (ssum - div_rsp.quotient) : (ssum + div_rsp.quotient);
            if (n == 4'd12) begin
              state <= S_SEND;
            end else begin
              n     <= n + 4'd1;
              opa   <= div_rsp.quotient;
              opb   <= a2;
              acc   <= '0;
              qc    <= '0;
              state <= S_QMUL;
            end
          end
        end
        S_SEND: begin
          if (odd) begin
            sa    <= to_q15(ssum);
            odd   <= 1'b0;
            state <= S_SINIT;
          end else begin
            ca    <= to_q15(ssum);
            state <= S_FIN;
          end
        end
        S_FIN: begin
          unique case (tfrac[15:14])
            2'd0: begin
              cos_r <= cq;
              sin_r <= sq;
            end
            2'd1: begin
              cos_r <= 16'd0 - sq;
              sin_r <= cq;
            end
            2'd2: begin
              cos_r <= 16'd0 - cq;
              sin_r <= 16'd0 - sq;
            end
            default: begin
              cos_r <= sq;
              sin_r <= 16'd0 - cq;
            end
          endcase
          state <= S_HOLD;
        end
        S_HOLD: begin
          if (res_ack) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign idle               = (state == S_IDLE);
  assign res_hold           = (state == S_HOLD);
  assign result.phase_index = idx;
  assign result.cos_value   = cos_r;
  assign result.sin_value   = sin_r;

endmodule
